// File: design/wsfd_pkg.sv
// wsfd_pkg: shared types, codes and helpers for the websocket frame deframer
// used by wsfd_decode, wsfd_out_stage and the top level
package wsfd_pkg;

  localparam int unsigned LenW   = 63;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TdataW = 120;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DEAD    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_MIN   = 2'd1;
  localparam logic [1:0] ST_TOP_BIT   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [7:0]      data;
    logic [3:0]      opcode;
    logic            fin;
    logic            rsv1;
    logic            rsv2;
    logic            rsv3;
    logic            masked;
    logic [LenW-1:0] frame_len;
    logic [KeyW-1:0] mask_key;
    logic [1:0]      status;
    logic            last;
  } result_t;

  // header length in bytes from header byte 1
  function automatic logic [3:0] hdr_total(input logic [7:0] b1);
    logic [3:0] n;
    n = 4'd2;
    if (b1[6:0] == LEN_CODE_16) begin
      n = 4'd4;
    end else if (b1[6:0] == LEN_CODE_64) begin
      n = 4'd10;
    end
    if (b1[7]) begin
      n = n + 4'd4;
    end
    return n;
  endfunction

endpackage

// File: design/websocket_frame_deframer_unit.sv
// websocket_frame_deframer_unit: byte-serial websocket frame decoder
// Slave stream s_*: one received byte per transaction in s_tdata.
// Master stream m_*: one result per transaction; m_tuser carries the kind
// (payload byte, frame header or error), m_tlast marks the final payload
// byte of a frame or a header whose payload length is zero.
// cfg_wr_en / cfg_wr_data set the largest accepted payload length.
// A byte is first held in the input register, then its result lands in
// the output register; a stall on m_tready can hold the byte in between,
// and the result stays on m_* until it is taken.
// Header bytes other than the last give no result.
// Throughput: one byte per cycle while m_tready does not hold the output,
// set by the single decode step between the input and output registers.
// Reset clears the pipeline, returns to header collection and sets the
// maximum length to all ones. After a length error the block drops every
// byte until reset. When m_tready is low the result holds and at most one
// more byte is taken into the input register before s_tready falls.
module websocket_frame_deframer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] data, [11:8] opcode, [12] fin, [13] rsv1, [14] rsv2, [15] rsv3,
  // [16] masked, [79:17] frame length, [111:80] mask key,
  // [113:112] status, [119:114] zero
  output logic [wsfd_pkg::TdataW-1:0]    m_tdata,
  output logic [1:0]                     m_tuser,   // [1:0] kind
  output logic                           m_tlast,
  input  logic                           cfg_wr_en,
  input  logic [wsfd_pkg::LenW-1:0]      cfg_wr_data
);

  logic              advance;
  logic              q_valid;
  logic [7:0]        q_byte;
  wsfd_pkg::result_t res;
  wsfd_pkg::result_t out_q;

  wsfd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_byte  (s_tdata),
    .advance (advance),
    .q_valid (q_valid),
    .q_byte  (q_byte)
  );

  wsfd_decode u_dec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .in_byte     (q_byte),
    .res         (res)
  );

  wsfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .res      (res),
    .advance  (advance),
    .m_ready  (m_tready),
    .m_valid  (m_tvalid),
    .q        (out_q)
  );

  assign m_tdata = {6'd0, out_q.status, out_q.mask_key, out_q.frame_len,
                    out_q.masked, out_q.rsv3, out_q.rsv2, out_q.rsv1, out_q.fin,
                    out_q.opcode, out_q.data};
  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;

  // payload results carry nothing but data and last
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == wsfd_pkg::KIND_PAYLOAD |-> m_tdata[119:8] == '0)
    else $error("payload result with header fields set");

  // an error result always names its cause and never ends a frame
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == wsfd_pkg::KIND_ERROR |->
      m_tdata[113:112] != wsfd_pkg::ST_OK && !m_tlast)
    else $error("error result without status");

  // a header ends the frame exactly when its payload length is zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == wsfd_pkg::KIND_HEADER |->
      m_tdata[113:112] == wsfd_pkg::ST_OK && (m_tlast == (m_tdata[79:17] == '0)))
    else $error("header result status or last mismatch");

endmodule

// File: design/wsfd_in_stage.sv
// wsfd_in_stage: input register for the received byte stream
// depends on nothing outside this file
module wsfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  input  logic       advance,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  assign s_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      q_byte <= s_byte;
    end
  end

endmodule

// File: design/wsfd_decode.sv
// wsfd_decode: header collection, length checks and payload unmasking
// depends on wsfd_pkg for the phase codes, result struct and hdr_total
module wsfd_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [wsfd_pkg::LenW-1:0] cfg_wr_data,
  input  logic                      advance,
  input  logic [7:0]                in_byte,
  output wsfd_pkg::result_t         res
);

  wsfd_pkg::phase_t phase, phase_next;
  logic [3:0]                hdr_count;
  logic [7:0]                byte0;
  logic [7:0]                byte1;
  logic [63:0]               len_sr;
  logic [23:0]               key_sr;
  logic [wsfd_pkg::LenW-1:0] bytes_remaining;
  logic [wsfd_pkg::KeyW-1:0] key_register;
  logic [1:0]                key_offset;
  logic [wsfd_pkg::LenW-1:0] max_frame_len;

  logic [7:0]                b1_cur;
  logic [6:0]                code;
  logic                      is_len_byte;
  logic                      hdr_done;
  logic [63:0]               len_full;
  logic [63:0]               len_dec;
  logic [wsfd_pkg::KeyW-1:0] key_full;
  logic [1:0]                status;
  logic [7:0]                key_byte;
  logic                      pay_last;

  assign b1_cur = (hdr_count == 4'd1) ? in_byte : byte1;
  assign code   = b1_cur[6:0];

  assign is_len_byte = (hdr_count >= 4'd2) &&
                       (((code == wsfd_pkg::LEN_CODE_16) && (hdr_count < 4'd4)) ||
                        ((code == wsfd_pkg::LEN_CODE_64) && (hdr_count < 4'd10)));

  assign hdr_done = (hdr_count != 4'd0) &&
                    ((hdr_count + 4'd1) >= wsfd_pkg::hdr_total(b1_cur));

  assign len_full = is_len_byte ? {len_sr[55:0], in_byte} : len_sr;
  // when masked the completing byte is the last key byte
  assign key_full = {key_sr, in_byte};

  always_comb begin
    len_dec = {57'd0, code};
    status  = wsfd_pkg::ST_OK;
    if (code == wsfd_pkg::LEN_CODE_16) begin
      len_dec = len_full;
      if (len_full <= 64'd125) begin
        status = wsfd_pkg::ST_NOT_MIN;
      end
    end else if (code == wsfd_pkg::LEN_CODE_64) begin
      len_dec = len_full;
      if (len_full[63]) begin
        status = wsfd_pkg::ST_TOP_BIT;
      end else if (len_full <= 64'd65535) begin
        status = wsfd_pkg::ST_NOT_MIN;
      end
    end
    if (status == wsfd_pkg::ST_OK && len_dec[62:0] > max_frame_len) begin
      status = wsfd_pkg::ST_TOO_LONG;
    end
  end

  always_comb begin
    case (key_offset)
      2'd0:    key_byte = key_register[31:24];
      2'd1:    key_byte = key_register[23:16];
      2'd2:    key_byte = key_register[15:8];
      default: key_byte = key_register[7:0];
    endcase
  end

  assign pay_last = (bytes_remaining == 63'd1);

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      wsfd_pkg::PH_HEADER: begin
        if (hdr_done) begin
          if (status != wsfd_pkg::ST_OK) begin
            phase_next = wsfd_pkg::PH_DEAD;
          end else if (len_dec != 64'd0) begin
            phase_next = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        if (pay_last) begin
          phase_next = wsfd_pkg::PH_HEADER;
        end
      end
      default: phase_next = phase;
    endcase
  end

  // result
  always_comb begin
    res = '0;
    case (phase)
      wsfd_pkg::PH_HEADER: begin
        if (hdr_done) begin
          res.valid     = 1'b1;
          res.opcode    = byte0[3:0];
          res.fin       = byte0[7];
          res.rsv1      = byte0[6];
          res.rsv2      = byte0[5];
          res.rsv3      = byte0[4];
          res.masked    = b1_cur[7];
          res.frame_len = len_dec[62:0];
          if (status != wsfd_pkg::ST_OK) begin
            res.kind   = wsfd_pkg::KIND_ERROR;
            res.status = status;
          end else begin
            res.kind     = wsfd_pkg::KIND_HEADER;
            res.mask_key = b1_cur[7] ? key_full : '0;
            res.last     = (len_dec == 64'd0);
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        res.valid = 1'b1;
        res.kind  = wsfd_pkg::KIND_PAYLOAD;
        res.data  = in_byte ^ key_byte;
        res.last  = pay_last;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= '1;
    end else if (cfg_wr_en) begin
      max_frame_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= wsfd_pkg::PH_HEADER;
      hdr_count       <= 4'd0;
      bytes_remaining <= '0;
      key_register    <= '0;
      key_offset      <= 2'd0;
    end else if (advance) begin
      phase <= phase_next;
      case (phase)
        wsfd_pkg::PH_HEADER: begin
          if (hdr_done) begin
            hdr_count <= 4'd0;
            if (status == wsfd_pkg::ST_OK) begin
              key_register    <= b1_cur[7] ? key_full : '0;
              key_offset      <= 2'd0;
              bytes_remaining <= len_dec[62:0];
            end
          end else begin
            hdr_count <= hdr_count + 4'd1;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          bytes_remaining <= bytes_remaining - 63'd1;
          key_offset      <= pay_last ? 2'd0 : key_offset + 2'd1;
        end
        default: hdr_count <= hdr_count;
      endcase
    end
  end

  // header byte collection, no reset needed
  always_ff @(posedge clk) begin
    if (advance && phase == wsfd_pkg::PH_HEADER) begin
      if (hdr_count == 4'd0) begin
        byte0  <= in_byte;
        len_sr <= '0;
      end
      if (hdr_count == 4'd1) begin
        byte1 <= in_byte;
      end
      if (is_len_byte) begin
        len_sr <= len_full;
      end else if (hdr_count >= 4'd2) begin
        key_sr <= key_full[23:0];
      end
    end
  end

endmodule

// File: design/wsfd_out_stage.sv
// wsfd_out_stage: result register toward the downstream stream
// depends on wsfd_pkg for the result struct
module wsfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  wsfd_pkg::result_t res,
  output logic              advance,
  input  logic              m_ready,
  output logic              m_valid,
  output wsfd_pkg::result_t q
);

  assign advance = in_valid && (!m_valid || m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= res.valid;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      q <= res;
    end
  end

endmodule

// File: bench/websocket_frame_deframer_unit_tb.sv
// websocket_frame_deframer_unit_tb: self-checking bench for the websocket frame deframer
// drives byte streams of framed headers and payloads, predicts every header, payload
// and error result in a scoreboard class; depends on wsfd_pkg and the top level only
`timescale 1ns / 1ps

module websocket_frame_deframer_unit_tb;

  localparam longint unsigned CycleLimit = 64'd200_000;
  localparam logic [62:0]     LenAllOnes = {63{1'b1}};

  typedef struct packed {
    wsfd_pkg::kind_t kind;
    logic [7:0]      data;
    logic [3:0]      opcode;
    logic            fin;
    logic            rsv1;
    logic            rsv2;
    logic            rsv3;
    logic            masked;
    logic [62:0]     frame_len;
    logic [31:0]     mask_key;
    logic [1:0]      status;
    logic            last;
  } deframed_t;

  class deframe_scoreboard;
    wsfd_pkg::phase_t ph;
    logic [7:0]       hdr [14];
    int unsigned      hcount;
    logic [62:0]      remaining;
    logic [31:0]      key;
    logic [1:0]       koff;
    logic [62:0]      max_len;
    deframed_t        deframed_q [$];
    int unsigned      errors;

    function new();
      ph = wsfd_pkg::PH_HEADER;
      hcount = 0;
      remaining = '0;
      key = '0;
      koff = '0;
      max_len = LenAllOnes;
      errors = 0;
    endfunction

    function void set_max_len(logic [62:0] v);
      max_len = v;
    endfunction

    function int unsigned header_bytes(logic [7:0] b1);
      int unsigned n;
      n = 2;
      if (b1[6:0] == wsfd_pkg::LEN_CODE_16) begin
        n = 4;
      end else if (b1[6:0] == wsfd_pkg::LEN_CODE_64) begin
        n = 10;
      end
      if (b1[7]) begin
        n = n + 4;
      end
      return n;
    endfunction

    function deframed_t decode_header();
      deframed_t   r;
      logic [63:0] len;
      logic [1:0]  st;
      int unsigned off;
      r = '0;
      len = '0;
      st = wsfd_pkg::ST_OK;
      off = 2;
      if (hdr[1][6:0] == wsfd_pkg::LEN_CODE_16) begin
        len = {48'd0, hdr[2], hdr[3]};
        off = 4;
        if (len <= 64'd125) st = wsfd_pkg::ST_NOT_MIN;
      end else if (hdr[1][6:0] == wsfd_pkg::LEN_CODE_64) begin
        for (int i = 0; i < 8; i++) len = {len[55:0], hdr[2 + i]};
        off = 10;
        if (len[63]) st = wsfd_pkg::ST_TOP_BIT;
        else if (len <= 64'd65535) st = wsfd_pkg::ST_NOT_MIN;
      end else begin
        len = {57'd0, hdr[1][6:0]};
      end
      if (st == wsfd_pkg::ST_OK && len > {1'b0, max_len}) st = wsfd_pkg::ST_TOO_LONG;
      r.opcode = hdr[0][3:0];
      r.fin = hdr[0][7];
      r.rsv1 = hdr[0][6];
      r.rsv2 = hdr[0][5];
      r.rsv3 = hdr[0][4];
      r.masked = hdr[1][7];
      r.frame_len = len[62:0];
      hcount = 0;
      if (st != wsfd_pkg::ST_OK) begin
        r.kind = wsfd_pkg::KIND_ERROR;
        r.status = st;
        ph = wsfd_pkg::PH_DEAD;
        return r;
      end
      r.kind = wsfd_pkg::KIND_HEADER;
      key = hdr[1][7] ? {hdr[off], hdr[off + 1], hdr[off + 2], hdr[off + 3]} : 32'd0;
      r.mask_key = key;
      koff = '0;
      if (len == 64'd0) begin
        r.last = 1'b1;
        ph = wsfd_pkg::PH_HEADER;
      end else begin
        remaining = len[62:0];
        ph = wsfd_pkg::PH_PAYLOAD;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      deframed_t r;
      r = '0;
      case (ph)
        wsfd_pkg::PH_HEADER: begin
          hdr[hcount] = b;
          hcount++;
          if (hcount >= 2 && hcount >= header_bytes(hdr[1])) begin
            deframed_q.push_back(decode_header());
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          // key bytes rotate from the most significant one down
          r.kind = wsfd_pkg::KIND_PAYLOAD;
          r.data = b ^ key[8 * (3 - int'(koff)) +: 8];
          koff = koff + 2'd1;
          remaining = remaining - 63'd1;
          if (remaining == '0) begin
            r.last = 1'b1;
            ph = wsfd_pkg::PH_HEADER;
            hcount = 0;
            koff = '0;
          end
          deframed_q.push_back(r);
        end
        default: ;  // dead: every byte is dropped
      endcase
    endfunction

    function void match(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] user, logic [wsfd_pkg::TdataW-1:0] td, logic tl);
      deframed_t want;
      if (deframed_q.size() == 0) begin
        $error("result with no prediction waiting: kind %0d tdata %0h", user, td);
        errors++;
        return;
      end
      want = deframed_q.pop_front();
      match("kind", 64'(want.kind), 64'(user));
      match("data", 64'(want.data), 64'(td[7:0]));
      match("opcode", 64'(want.opcode), 64'(td[11:8]));
      match("fin", 64'(want.fin), 64'(td[12]));
      match("rsv1", 64'(want.rsv1), 64'(td[13]));
      match("rsv2", 64'(want.rsv2), 64'(td[14]));
      match("rsv3", 64'(want.rsv3), 64'(td[15]));
      match("masked", 64'(want.masked), 64'(td[16]));
      match("frame_len", 64'(want.frame_len), 64'(td[79:17]));
      match("mask_key", 64'(want.mask_key), 64'(td[111:80]));
      match("status", 64'(want.status), 64'(td[113:112]));
      match("last", 64'(want.last), 64'(tl));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [wsfd_pkg::TdataW-1:0]   m_tdata;
  logic [1:0]                    m_tuser;
  logic                          m_tlast;
  logic                          cfg_wr_en = 1'b0;
  logic [wsfd_pkg::LenW-1:0]     cfg_wr_data = '0;

  deframe_scoreboard sb;
  longint unsigned   cycles = 0;
  int unsigned       sent_bytes = 0;
  bit                send_burst = 1'b0;
  bit                recv_burst = 1'b0;

  websocket_frame_deframer_unit uut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall before each transaction, burst stretches without
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_result(m_tuser, m_tdata, m_tlast);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  // stop sending and let every predicted result arrive
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.deframed_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [62:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_len(v);
  endtask

  task automatic send_header(input logic [7:0] b0, input logic m, input logic [6:0] code,
                             input logic [63:0] ext, input logic [31:0] k);
    send_byte(b0);
    send_byte({m, code});
    if (code == wsfd_pkg::LEN_CODE_16) begin
      send_byte(ext[15:8]);
      send_byte(ext[7:0]);
    end else if (code == wsfd_pkg::LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) send_byte(ext[8 * i +: 8]);
    end
    if (m) begin
      for (int i = 3; i >= 0; i--) send_byte(k[8 * i +: 8]);
    end
  endtask

  function automatic logic [6:0] len_code(input logic [63:0] len);
    if (len <= 64'd125) return len[6:0];
    if (len <= 64'd65535) return wsfd_pkg::LEN_CODE_16;
    return wsfd_pkg::LEN_CODE_64;
  endfunction

  task automatic send_frame(input logic [7:0] b0, input logic m, input logic [62:0] len);
    send_header(b0, m, len_code({1'b0, len}), {1'b0, len}, $urandom);
    for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // mostly short payloads, some up to the 7-bit limit, a few 16-bit lengths
  task automatic rand_frame(input logic [62:0] lim);
    int unsigned pick;
    logic [62:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = 63'($urandom_range(0, 12));
    else if (pick < 90) len = 63'($urandom_range(0, 125));
    else len = 63'($urandom_range(126, 400));
    if (len > lim) len = 63'($urandom_range(0, int'(lim[8:0])));
    send_burst = ($urandom_range(0, 7) == 0);
    send_frame(8'($urandom), 1'($urandom), len);
    if ($urandom_range(0, 19) == 0) wait_drain();
  endtask

  initial begin
    int unsigned sel;
    logic [62:0] lim;
    logic [63:0] len;
    logic        m;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: header bit extremes, zero lengths, key rotation, all-zero and all-one keys
    send_frame(8'h81, 1'b0, 63'd0);
    send_frame(8'hFF, 1'b1, 63'd0);
    send_frame(8'h00, 1'b1, 63'd1);
    send_frame(8'h4A, 1'b1, 63'd6);
    send_header(8'h88, 1'b1, 7'd2, 64'd0, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(8'h31, 1'b1, 7'd1, 64'd0, 32'h0000_0000);
    send_byte(8'hA5);
    send_frame(8'h7F, 1'b0, 63'd3);
    wait_drain();

    // a zero limit lets only empty frames through
    write_max_len(63'd0);
    repeat (20) send_frame(8'($urandom), 1'($urandom), 63'd0);
    wait_drain();

    lim = 63'($urandom_range(1, 300));
    write_max_len(lim);
    while (sent_bytes < 700) rand_frame(lim);
    wait_drain();

    write_max_len(LenAllOnes);
    while (sent_bytes < 2000) rand_frame(LenAllOnes);
    wait_drain();

    // one length error ends the stream; the block then drops all bytes
    sel = $urandom_range(0, 3);
    m = 1'($urandom);
    case (sel)
      0: send_header(8'($urandom), m, wsfd_pkg::LEN_CODE_16,
                     64'($urandom_range(0, 125)), $urandom);
      1: send_header(8'($urandom), m, wsfd_pkg::LEN_CODE_64,
                     {1'b1, $urandom, 31'($urandom)}, $urandom);
      2: send_header(8'($urandom), m, wsfd_pkg::LEN_CODE_64,
                     64'($urandom_range(0, 65535)), $urandom);
      default: begin
        lim = {1'b0, 62'({$urandom, $urandom})} >> $urandom_range(0, 62);
        write_max_len(lim);
        len = {1'b0, lim} + 64'd1 + 64'($urandom_range(0, 1000));
        send_header(8'($urandom), m, len_code(len), len, $urandom);
      end
    endcase
    repeat (30) send_byte(8'($urandom));
    wait_drain();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.deframed_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
